// ===== sv/abe_pkg.sv =====
`timescale 1ns / 1ps

package abe_pkg;

    // fixed widths of the item fields
    localparam int FIELD_W = 13;
    localparam int MPOS_W  = 12;

    // item kinds
    localparam logic REQ_COLUMN = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // configuration register indexes
    localparam logic REG_BAND_MODE  = 1'b0;
    localparam logic REG_BAND_WIDTH = 1'b1;

    // window modes
    localparam logic MODE_EXACT  = 1'b0;
    localparam logic MODE_BANDED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_A,
        ST_ROW_B,
        ST_MAT_A,
        ST_MAT_B,
        ST_FIN
    } abe_state_t;

endpackage

// ===== sv/abe_ram.sv =====
`timescale 1ns / 1ps

module abe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/alignment_band_envelope_core.sv =====
`timescale 1ns / 1ps

// Alignment band envelope. Column items (req_type 0) carry the input and output
// flags of one alignment column and are taken without stalling: counts update and,
// for a match column, the input position goes to the match memory, while a column
// that emits an output symbol records its new row (matches before it, input position
// that created it, whether it was a match) in the row memory. Query items
// (req_type 1) return the input window [row_start, row_end) of one row: exact mode
// follows the path cells, banded mode reaches band_width matches to either side of
// the path. Both memories have one read port with registered data, so a query runs
// as a chain of dependent reads: exact mode reads row j then row j+1, banded mode
// reads row j then two match positions; the last step holds while an earlier result
// still waits on the result channel. Columns accept back to back at one per cycle
// while no query is in progress. Row 0 is implied (all zero) and no memory needs a
// clearing pass after reset. Lengths that would exceed MAX_LEN drop the column and
// set the sticky overflow flag, which clears on the next first_column. Configuration
// writes are taken at any time and are meant to arrive only while no query is in
// progress.
module alignment_band_envelope_core
    import abe_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,

    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [FIELD_W-1:0] cfg_data,

    // item channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic               s_first_column,
    input  logic               s_has_input,
    input  logic               s_has_output,
    input  logic [FIELD_W-1:0] s_row_index,

    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_row_start,
    output logic [FIELD_W-1:0] m_row_end,
    output logic               m_row_valid,
    output logic [FIELD_W-1:0] m_input_length,
    output logic [FIELD_W-1:0] m_output_length,
    output logic               m_overflow
);

    // count width, also the row memory address width (depth MAX_LEN + 1)
    localparam int CW   = $clog2(MAX_LEN + 1);
    // match memory address width (depth MAX_LEN)
    localparam int AW_M = $clog2(MAX_LEN);
    // compare width covering both counts and 13-bit fields, plus one for sums
    localparam int XW   = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int SW   = XW + 1;
    // row word: matches before row, creating input position, match flag
    localparam int RW   = 2 * CW + 1;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

    // configuration registers
    logic               band_mode_reg;
    logic [FIELD_W-1:0] band_width_reg;

    // alignment state
    logic [CW-1:0] ic_reg, ic_next;
    logic [CW-1:0] oc_reg, oc_next;
    logic [CW-1:0] mc_reg, mc_next;
    logic          ovf_reg, ovf_next;

    abe_state_t state_reg, state_next;

    // query working registers
    logic [FIELD_W-1:0] j_reg, j_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      cr_reg, cr_next;
    logic               fm_reg, fm_next;
    logic [CW-1:0]      crn_reg, crn_next;
    logic [MPOS_W-1:0]  ma_reg, ma_next;
    logic [MPOS_W-1:0]  mb_reg, mb_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0] start_reg, start_next;
    logic [FIELD_W-1:0] end_reg, end_next;
    logic               rvalid_reg, rvalid_next;
    logic [FIELD_W-1:0] ilen_reg, ilen_next;
    logic [FIELD_W-1:0] olen_reg, olen_next;
    logic               rovf_reg, rovf_next;

    // memory ports
    logic              mpos_we;
    logic [AW_M-1:0]   mpos_waddr;
    logic [MPOS_W-1:0] mpos_wdata;
    logic [AW_M-1:0]   mpos_raddr;
    logic [MPOS_W-1:0] mpos_rdata;

    logic              row_we;
    logic [CW-1:0]     row_waddr;
    logic [RW-1:0]     row_wdata;
    logic [CW-1:0]     row_raddr;
    logic [RW-1:0]     row_rdata;

    // column datapath
    logic          s_xfer;
    logic          col_xfer;
    logic [CW-1:0] ic_eff, oc_eff, mc_eff;
    logic          is_match;
    logic          col_drop;
    logic          add_match;
    logic [CW-1:0] mc_new;

    // query datapath
    logic [XW-1:0] j_x;
    logic [RW-1:0] row_word;
    logic [CW-1:0] row_n;
    logic [SW-1:0] lo_addr;
    logic [SW-1:0] hi_addr;
    logic          q_valid;
    logic          q_last;
    logic          n_gt_bw;
    logic [SW-1:0] match_diff;
    logic          hi_bounded;
    logic [SW-1:0] start_w;
    logic [SW-1:0] end_w;
    logic          out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign col_xfer  = s_xfer && (s_req_type == REQ_COLUMN);
    assign out_free  = !m_valid_reg || m_ready;

    // a first column clears the counts before the column itself is taken
    assign ic_eff   = s_first_column ? '0 : ic_reg;
    assign oc_eff   = s_first_column ? '0 : oc_reg;
    assign mc_eff   = s_first_column ? '0 : mc_reg;
    assign is_match = s_has_input && s_has_output;
    assign col_drop = (s_has_input && (ic_eff >= MAX_CNT))
                   || (s_has_output && (oc_eff >= MAX_CNT));
    assign add_match = is_match && (mc_eff < MAX_CNT);
    assign mc_new    = mc_eff + CW'(add_match);

    assign mpos_we    = col_xfer && !col_drop && add_match;
    assign mpos_waddr = mc_eff[AW_M-1:0];
    assign mpos_wdata = MPOS_W'(ic_eff);

    // new row lands at output count + 1; row 0 is never written
    assign row_we    = col_xfer && !col_drop && s_has_output;
    assign row_waddr = oc_eff + CW'(1);
    assign row_wdata = {mc_new, ic_eff, is_match};

    // row 0 reads as all zero
    assign j_x      = XW'(j_reg);
    assign row_word = (j_reg == '0) ? '0 : row_rdata;
    assign row_n    = row_word[RW-1 -: CW];

    // band edges in match index space
    assign lo_addr = SW'(row_n) - SW'(band_width_reg) - SW'(1);
    assign hi_addr = SW'(n_reg) + SW'(band_width_reg);

    // result terms
    assign q_valid    = j_x <= XW'(oc_reg);
    assign q_last     = !(j_x < XW'(oc_reg));
    assign n_gt_bw    = SW'(n_reg) > SW'(band_width_reg);
    assign match_diff = SW'(mc_reg) - SW'(n_reg);
    assign hi_bounded = (mc_reg >= n_reg) && (match_diff > SW'(band_width_reg));

    always_comb begin
        if (band_mode_reg == MODE_EXACT) begin
            start_w = SW'(cr_reg) + SW'(fm_reg);
            end_w   = q_last ? (SW'(ic_reg) + SW'(1)) : (SW'(crn_reg) + SW'(1));
        end else begin
            start_w = n_gt_bw ? (SW'(ma_reg) + SW'(1)) : '0;
            end_w   = hi_bounded ? (SW'(mb_reg) + SW'(1)) : (SW'(ic_reg) + SW'(1));
        end
    end

    // column update, query sequencer and result register
    always_comb begin
        state_next   = state_reg;
        ic_next      = ic_reg;
        oc_next      = oc_reg;
        mc_next      = mc_reg;
        ovf_next     = ovf_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        cr_next      = cr_reg;
        fm_next      = fm_reg;
        crn_next     = crn_reg;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        m_valid_next = m_valid_reg && !m_ready;
        start_next   = start_reg;
        end_next     = end_reg;
        rvalid_next  = rvalid_reg;
        ilen_next    = ilen_reg;
        olen_next    = olen_reg;
        rovf_next    = rovf_reg;
        row_raddr    = CW'(XW'(s_row_index));
        mpos_raddr   = lo_addr[AW_M-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_req_type == REQ_COLUMN) begin
                        ic_next  = ic_eff;
                        oc_next  = oc_eff;
                        mc_next  = mc_eff;
                        ovf_next = s_first_column ? 1'b0 : ovf_reg;
                        if (col_drop) begin
                            ovf_next = 1'b1;
                        end else begin
                            mc_next = mc_new;
                            ic_next = ic_eff + CW'(s_has_input);
                            oc_next = oc_eff + CW'(s_has_output);
                        end
                    end else begin
                        // row read for j issued here
                        j_next     = s_row_index;
                        state_next = ST_ROW_A;
                    end
                end
            end
            ST_ROW_A: begin
                n_next  = row_n;
                cr_next = row_word[CW:1];
                fm_next = row_word[0];
                if (band_mode_reg == MODE_EXACT) begin
                    row_raddr  = CW'(j_x) + CW'(1);
                    state_next = ST_ROW_B;
                end else begin
                    mpos_raddr = lo_addr[AW_M-1:0];
                    state_next = ST_MAT_A;
                end
            end
            ST_ROW_B: begin
                crn_next   = row_rdata[CW:1];
                state_next = ST_FIN;
            end
            ST_MAT_A: begin
                ma_next    = mpos_rdata;
                mpos_raddr = hi_addr[AW_M-1:0];
                state_next = ST_MAT_B;
            end
            ST_MAT_B: begin
                mb_next    = mpos_rdata;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // wait for the result slot to free up
                if (out_free) begin
                    m_valid_next = 1'b1;
                    start_next   = q_valid ? start_w[FIELD_W-1:0] : '0;
                    end_next     = q_valid ? end_w[FIELD_W-1:0] : '0;
                    rvalid_next  = q_valid;
                    ilen_next    = FIELD_W'(ic_reg);
                    olen_next    = FIELD_W'(oc_reg);
                    rovf_next    = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ic_reg         <= '0;
            oc_reg         <= '0;
            mc_reg         <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            band_mode_reg  <= MODE_EXACT;
            band_width_reg <= '0;
        end else begin
            state_reg   <= state_next;
            ic_reg      <= ic_next;
            oc_reg      <= oc_next;
            mc_reg      <= mc_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_BAND_MODE:  band_mode_reg  <= cfg_data[0];
                    REG_BAND_WIDTH: band_width_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        j_reg      <= j_next;
        n_reg      <= n_next;
        cr_reg     <= cr_next;
        fm_reg     <= fm_next;
        crn_reg    <= crn_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        rvalid_reg <= rvalid_next;
        ilen_reg   <= ilen_next;
        olen_reg   <= olen_next;
        rovf_reg   <= rovf_next;
    end

    // input position of every match column
    abe_ram #(
        .WIDTH (MPOS_W),
        .DEPTH (MAX_LEN)
    ) u_match_mem (
        .aclk  (aclk),
        .we    (mpos_we),
        .waddr (mpos_waddr),
        .wdata (mpos_wdata),
        .raddr (mpos_raddr),
        .rdata (mpos_rdata)
    );

    // per-row record, entry 0 implied
    abe_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_LEN + 1)
    ) u_row_mem (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    assign m_valid         = m_valid_reg;
    assign m_row_start     = start_reg;
    assign m_row_end       = end_reg;
    assign m_row_valid     = rvalid_reg;
    assign m_input_length  = ilen_reg;
    assign m_output_length = olen_reg;
    assign m_overflow      = rovf_reg;

endmodule

// ===== sv/abe_checker.sv =====
`timescale 1ns / 1ps

module abe_checker
    import abe_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               cfg_index,
    input logic [FIELD_W-1:0] cfg_data,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_req_type,
    input logic               s_first_column,
    input logic               s_has_input,
    input logic               s_has_output,
    input logic [FIELD_W-1:0] s_row_index,
    input logic               m_valid,
    input logic               m_ready,
    input logic [FIELD_W-1:0] m_row_start,
    input logic [FIELD_W-1:0] m_row_end,
    input logic               m_row_valid,
    input logic [FIELD_W-1:0] m_input_length,
    input logic [FIELD_W-1:0] m_output_length,
    input logic               m_overflow
);

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_row_start)
            && $stable(m_row_end) && $stable(m_row_valid)
            && $stable(m_input_length) && $stable(m_output_length)
            && $stable(m_overflow)))
        else $error("result changed while stalled");

    // out-of-range row gives an empty window
    a_empty_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_row_valid) |-> (m_row_start == '0 && m_row_end == '0))
        else $error("invalid row with nonzero window");

    // a query transfer blocks the input for the memory reads
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_QUERY) |=> !s_ready)
        else $error("input ready right after a query");

    // a column transfer leaves the input ready
    a_column_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_COLUMN) |=> s_ready)
        else $error("column held the input");

    // reset empties the result slot and opens the input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("bad state after reset");

endmodule

bind alignment_band_envelope_core abe_checker u_abe_checker (.*);
